### src/lca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lca_pkg
// Shared types and constants for the leader cluster assigner.
// ----------------------------------------------------------------------------
package lca_pkg;

    localparam int DEF_MAX_CLUSTERS = 8;
    localparam int DEF_MAX_FEATURES = 16;

    localparam int VALUE_W   = 16;
    localparam int DIST_W    = 40;
    localparam int COUNT_W   = 24;
    localparam int FC_W      = 5;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 40;

    localparam logic [DIST_W-1:0] THRESHOLD_RESET = 40'd65536;
    localparam logic [FC_W-1:0]   FEATURE_COUNT_RESET = 5'd16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEATURE_COUNT = 4'd1;

    typedef struct packed {
        logic signed [15:0] feature_value;
        logic               feature_valid;
    } lca_in_t;

    typedef struct packed {
        logic [2:0] cluster_label;
        logic       opened_cluster;
        logic [3:0] clusters_in_use;
    } lca_out_t;

    // control from the sequencer to every cell
    typedef struct packed {
        logic acc_en;
        logic acc_first;
        logic elem_valid;
        logic wr_en;
        logic cnt_inc;
    } lca_cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_DIST,
        ST_DRAIN,
        ST_SCAN,
        ST_DECIDE,
        ST_MEAN,
        ST_WAIT,
        ST_OUT
    } lca_state_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_MUL,
        DV_ADD,
        DV_ITER
    } lca_div_state_t;

endpackage

### src/lca_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lca_cell
// One cluster: centroid, member count, distance accumulator and one stage
// of the registered nearest-centroid chain.
// ----------------------------------------------------------------------------
module lca_cell #(
    parameter int MAX_FEATURES = 16,
    parameter int MAX_CLUSTERS = 8,
    parameter int CELL_INDEX   = 0,
    localparam int FIDX_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1,
    localparam int CIDX_W = $clog2(MAX_CLUSTERS)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lca_pkg::lca_cell_ctrl_t     ctrl,
    input  logic                        sel,
    input  logic                        cell_open,
    input  logic [FIDX_W-1:0]           addr,
    input  logic signed [15:0]          row_value,
    input  logic signed [15:0]          wr_value,
    input  logic                        chain_in_any,
    input  logic [lca_pkg::DIST_W-1:0]  chain_in_dist,
    input  logic [CIDX_W-1:0]           chain_in_idx,
    output logic signed [15:0]          rd_value,
    output logic [lca_pkg::COUNT_W-1:0] count_value,
    output logic                        chain_out_any,
    output logic [lca_pkg::DIST_W-1:0]  chain_out_dist,
    output logic [CIDX_W-1:0]           chain_out_idx
);
    import lca_pkg::*;

    logic signed [15:0]  centroid_reg [MAX_FEATURES];
    logic [COUNT_W-1:0]  count_reg;
    logic [31:0]         prod_reg, prod_next;
    logic                prodv_reg, prodfirst_reg;
    logic [DIST_W-1:0]   acc_reg;
    logic                best_any_reg;
    logic [DIST_W-1:0]   best_dist_reg;
    logic [CIDX_W-1:0]   best_idx_reg;
    logic signed [16:0]  diff;
    logic signed [33:0]  sq;
    logic                take_own;

    assign rd_value    = centroid_reg[addr];
    assign count_value = count_reg;

    // centroid and member count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_FEATURES; i++) begin
                centroid_reg[i] <= '0;
            end
            count_reg <= '0;
        end else begin
            if (ctrl.wr_en && sel) begin
                centroid_reg[addr] <= wr_value;
            end
            if (ctrl.cnt_inc && sel && (count_reg != {COUNT_W{1'b1}})) begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // squared difference of one element
    always_comb begin
        diff      = $signed({row_value[15], row_value}) - $signed({rd_value[15], rd_value});
        sq        = diff * diff;
        prod_next = ctrl.elem_valid ? sq[31:0] : 32'd0;
    end

    // product stage, then accumulate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prodv_reg <= 1'b0;
        end else begin
            prodv_reg <= ctrl.acc_en;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg      <= prod_next;
        prodfirst_reg <= ctrl.acc_first;
        if (prodv_reg) begin
            acc_reg <= prodfirst_reg ? DIST_W'(prod_reg) : acc_reg + DIST_W'(prod_reg);
        end
    end

    // nearest-centroid chain stage; ties keep the lower index
    assign take_own = cell_open && (!chain_in_any || (acc_reg < chain_in_dist));

    always_ff @(posedge aclk) begin
        if (take_own) begin
            best_any_reg  <= 1'b1;
            best_dist_reg <= acc_reg;
            best_idx_reg  <= CIDX_W'(CELL_INDEX);
        end else begin
            best_any_reg  <= chain_in_any;
            best_dist_reg <= chain_in_dist;
            best_idx_reg  <= chain_in_idx;
        end
    end

    assign chain_out_any  = best_any_reg;
    assign chain_out_dist = best_dist_reg;
    assign chain_out_idx  = best_idx_reg;

endmodule

### src/lca_mean_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lca_mean_div
// Running mean of one element: (old * (n - 1) + x) / n, truncated toward
// zero, by a restoring divider that makes one quotient bit a cycle.
// ----------------------------------------------------------------------------
module lca_mean_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic signed [15:0]          old_value,
    input  logic signed [15:0]          x_value,
    input  logic [lca_pkg::COUNT_W-1:0] n_value,
    output logic                        done,
    output logic signed [15:0]          mean_value
);
    import lca_pkg::*;

    lca_div_state_t     state_reg, state_next;
    logic               latch_en, mul_en, add_en, iter_en;
    logic signed [15:0] old_reg, x_reg;
    logic [COUNT_W-1:0] n_reg;
    logic signed [40:0] prod_reg;
    logic signed [41:0] num;
    logic [41:0]        rem_reg;
    logic [41:0]        dvs_reg;
    logic               neg_reg;
    logic [15:0]        q_reg;
    logic [3:0]         step_reg;
    logic               done_reg;
    logic               ge;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            DV_IDLE: if (start) state_next = DV_MUL;
            DV_MUL:  state_next = DV_ADD;
            DV_ADD:  state_next = DV_ITER;
            DV_ITER: if (step_reg == 4'd0) state_next = DV_IDLE;
            default: state_next = DV_IDLE;
        endcase
    end

    // stage enables
    always_comb begin
        latch_en = 1'b0;
        mul_en   = 1'b0;
        add_en   = 1'b0;
        iter_en  = 1'b0;
        case (state_reg)
            DV_IDLE: latch_en = start;
            DV_MUL:  mul_en   = 1'b1;
            DV_ADD:  add_en   = 1'b1;
            DV_ITER: iter_en  = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DV_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= iter_en && (step_reg == 4'd0);
        end
    end

    assign num = prod_reg + x_reg;
    assign ge  = (rem_reg >= dvs_reg);

    // datapath
    always_ff @(posedge aclk) begin
        if (latch_en) begin
            old_reg <= old_value;
            x_reg   <= x_value;
            n_reg   <= n_value;
        end
        if (mul_en) begin
            prod_reg <= old_reg * $signed({1'b0, n_reg - 1'b1});
        end
        if (add_en) begin
            neg_reg  <= num[41];
            rem_reg  <= num[41] ? 42'(-num) : 42'(num);
            dvs_reg  <= 42'(n_reg) << 15;
            step_reg <= 4'd15;
        end
        if (iter_en) begin
            if (ge) begin
                rem_reg <= rem_reg - dvs_reg;
            end
            q_reg    <= {q_reg[14:0], ge};
            dvs_reg  <= dvs_reg >> 1;
            step_reg <= step_reg - 1'b1;
        end
    end

    assign done       = done_reg;
    assign mean_value = neg_reg ? $signed(-q_reg) : $signed(q_reg);

endmodule

### src/leader_cluster_assigner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leader_cluster_assigner_core
// Online leader clustering over feature rows with a running-mean centroid
// update; one label item per completed row.
// ----------------------------------------------------------------------------
// Non-final element items are taken back to back while a row is collected.
// After the last element of a row the cells accumulate distances, the
// chain drains and is scanned, and the nearest cluster is chosen. The mean
// step then writes the row as is for a seeded row, or runs the divider on each
// valid element and skips masked ones. The result register is loaded once the
// previous label has been taken; no element of the next row is taken before.
// Reset clears centroids, counts, open clusters and the row position and
// restores threshold 65536 and feature count 16.
module leader_cluster_assigner_core #(
    parameter int MAX_CLUSTERS = lca_pkg::DEF_MAX_CLUSTERS,
    parameter int MAX_FEATURES = lca_pkg::DEF_MAX_FEATURES
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  lca_pkg::lca_in_t               s_item,
    output logic                           m_valid,
    input  logic                           m_ready,
    output lca_pkg::lca_out_t              m_item,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lca_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lca_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lca_pkg::*;

    localparam int FIDX_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int CIDX_W = $clog2(MAX_CLUSTERS);
    localparam int OPEN_W = $clog2(MAX_CLUSTERS + 1);
    localparam int DIM_W  = $clog2(MAX_FEATURES + 1);
    localparam int CNT_MAX = (MAX_CLUSTERS > MAX_FEATURES) ? MAX_CLUSTERS : MAX_FEATURES;
    localparam int CNT_W  = (CNT_MAX > 1) ? $clog2(CNT_MAX) : 1;

    lca_state_t         state_reg, state_next;
    logic [DIST_W-1:0]  thr_reg;
    logic [FC_W-1:0]    fc_reg;
    logic [DIM_W-1:0]   dims;
    logic [FIDX_W-1:0]  pos_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [FIDX_W-1:0]  elem;
    logic [OPEN_W-1:0]  open_reg;
    logic [CIDX_W-1:0]  best_reg, choice, sel_idx;
    logic               opened_reg, opened_c, full;
    logic signed [15:0] row_val_reg [MAX_FEATURES];
    logic               row_vld_reg [MAX_FEATURES];
    logic               in_accept, row_last, elem_last, scan_last;
    logic               div_start, div_done, load_out;
    logic signed [15:0] div_q, wr_value, old_value;
    logic [COUNT_W-1:0] n_value;
    lca_cell_ctrl_t     ctrl;
    logic               m_valid_reg;
    lca_out_t           m_item_reg;

    logic               chain_any  [MAX_CLUSTERS+1];
    logic [DIST_W-1:0]  chain_dist [MAX_CLUSTERS+1];
    logic [CIDX_W-1:0]  chain_idx  [MAX_CLUSTERS+1];
    logic signed [15:0] cell_rd    [MAX_CLUSTERS];
    logic [COUNT_W-1:0] cell_count [MAX_CLUSTERS];

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THRESHOLD_RESET;
            fc_reg  <= FEATURE_COUNT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_THRESHOLD:     thr_reg <= cfg_data[DIST_W-1:0];
                REG_FEATURE_COUNT: fc_reg  <= cfg_data[FC_W-1:0];
                default: ;
            endcase
        end
    end

    // effective row length
    always_comb begin
        if (fc_reg == '0) begin
            dims = DIM_W'(1);
        end else if (32'(fc_reg) > MAX_FEATURES) begin
            dims = DIM_W'(MAX_FEATURES);
        end else begin
            dims = DIM_W'(fc_reg);
        end
    end

    assign elem      = cnt_reg[FIDX_W-1:0];
    assign in_accept = s_valid && s_ready;
    assign row_last  = (32'(pos_reg) + 1 >= 32'(dims));
    assign elem_last = (32'(cnt_reg) + 1 >= 32'(dims));
    assign scan_last = (32'(cnt_reg) == MAX_CLUSTERS - 1);

    // row buffer and element position
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            row_val_reg[pos_reg] <= s_item.feature_value;
            row_vld_reg[pos_reg] <= s_item.feature_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (in_accept) begin
            pos_reg <= row_last ? '0 : pos_reg + 1'b1;
        end
    end

    // decision from the end of the chain
    assign full     = (32'(open_reg) == MAX_CLUSTERS);
    assign opened_c = !chain_any[MAX_CLUSTERS] || (chain_dist[MAX_CLUSTERS] > thr_reg);
    always_comb begin
        if (!opened_c) begin
            choice = chain_idx[MAX_CLUSTERS];
        end else if (full) begin
            choice = CIDX_W'(MAX_CLUSTERS - 1);
        end else begin
            choice = open_reg[CIDX_W-1:0];
        end
    end
    assign sel_idx = (state_reg == ST_DECIDE) ? choice : best_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_COLLECT: if (in_accept && row_last) state_next = ST_DIST;
            ST_DIST:    if (elem_last) state_next = ST_DRAIN;
            ST_DRAIN:   state_next = ST_SCAN;
            ST_SCAN:    if (scan_last) state_next = ST_DECIDE;
            ST_DECIDE:  state_next = ST_MEAN;
            ST_MEAN: begin
                if (div_start) begin
                    state_next = ST_WAIT;
                end else if (elem_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_WAIT: begin
                if (div_done) begin
                    state_next = elem_last ? ST_OUT : ST_MEAN;
                end
            end
            ST_OUT:     if (!m_valid_reg || m_ready) state_next = ST_COLLECT;
            default:    state_next = ST_COLLECT;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready        = 1'b0;
        ctrl           = '0;
        div_start      = 1'b0;
        load_out       = 1'b0;
        cnt_next       = '0;
        ctrl.acc_first = (cnt_reg == '0);
        ctrl.elem_valid = row_vld_reg[elem];
        case (state_reg)
            ST_COLLECT: s_ready = 1'b1;
            ST_DIST: begin
                ctrl.acc_en = 1'b1;
                cnt_next    = elem_last ? '0 : cnt_reg + 1'b1;
            end
            ST_DRAIN: ;
            ST_SCAN:    cnt_next = scan_last ? '0 : cnt_reg + 1'b1;
            ST_DECIDE:  ctrl.cnt_inc = 1'b1;
            ST_MEAN: begin
                ctrl.wr_en = opened_reg;
                div_start  = !opened_reg && row_vld_reg[elem];
                cnt_next   = div_start ? cnt_reg : cnt_reg + 1'b1;
            end
            ST_WAIT: begin
                ctrl.wr_en = div_done;
                cnt_next   = div_done ? cnt_reg + 1'b1 : cnt_reg;
            end
            ST_OUT:     load_out = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_COLLECT;
            cnt_reg   <= '0;
            open_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (state_reg == ST_DECIDE && opened_c && !full) begin
                open_reg <= open_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DECIDE) begin
            best_reg   <= choice;
            opened_reg <= opened_c;
        end
    end

    // selected cluster data for the mean step
    assign old_value = cell_rd[sel_idx];
    assign n_value   = cell_count[sel_idx];
    assign wr_value  = opened_reg ? row_val_reg[elem] : div_q;

    lca_mean_div u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (div_start),
        .old_value  (old_value),
        .x_value    (row_val_reg[elem]),
        .n_value    (n_value),
        .done       (div_done),
        .mean_value (div_q)
    );

    // row of cluster cells
    assign chain_any[0]  = 1'b0;
    assign chain_dist[0] = '0;
    assign chain_idx[0]  = '0;

    for (genvar i = 0; i < MAX_CLUSTERS; i++) begin : g_cell
        lca_cell #(
            .MAX_FEATURES (MAX_FEATURES),
            .MAX_CLUSTERS (MAX_CLUSTERS),
            .CELL_INDEX   (i)
        ) u_cell (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .ctrl           (ctrl),
            .sel            (sel_idx == CIDX_W'(i)),
            .cell_open      (32'(open_reg) > i),
            .addr           (elem),
            .row_value      (row_val_reg[elem]),
            .wr_value       (wr_value),
            .chain_in_any   (chain_any[i]),
            .chain_in_dist  (chain_dist[i]),
            .chain_in_idx   (chain_idx[i]),
            .rd_value       (cell_rd[i]),
            .count_value    (cell_count[i]),
            .chain_out_any  (chain_any[i+1]),
            .chain_out_dist (chain_dist[i+1]),
            .chain_out_idx  (chain_idx[i+1])
        );
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_item_reg.cluster_label   <= 3'(best_reg);
            m_item_reg.opened_cluster  <= opened_reg;
            m_item_reg.clusters_in_use <= 4'(open_reg);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // checks
    a_open_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(open_reg) <= MAX_CLUSTERS)
        else $error("open cluster count above limit");

    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_WAIT))
        else $error("divider result outside wait state");

    a_row_end_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && row_last) |=> !s_ready)
        else $error("item taken during row processing");

    a_label_opened: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.opened_cluster == 1'b0) |-> (m_item.clusters_in_use != 4'd0))
        else $error("row joined a cluster while none is open");

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the leader cluster assigner: element items are fed
// through a queue-driven driver, labels are predicted by a behavioral copy of
// the clustering and compared by a clocked monitor, across several
// threshold and row-length settings and several idling phases.
// ----------------------------------------------------------------------------
module tb;
    import lca_pkg::*;

    localparam int NCLU = DEF_MAX_CLUSTERS;
    localparam int NFEAT = DEF_MAX_FEATURES;
    localparam logic [COUNT_W-1:0] COUNT_SAT = '1;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int ROW_LATENCY = 400;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    lca_in_t s_item = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    lca_out_t m_item;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    leader_cluster_assigner_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic [DIST_W-1:0] thr_q;
    logic [FC_W-1:0] fcount_q;
    logic signed [VALUE_W-1:0] row_val [NFEAT];
    logic row_vld [NFEAT];
    logic signed [VALUE_W-1:0] centroid [NCLU][NFEAT];
    logic [COUNT_W-1:0] members [NCLU];
    int unsigned n_open;
    int unsigned elem_pos;

    lca_in_t pending_items[$];
    lca_out_t expected_labels[$];
    int error_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int idle_cycles = 0;
    bit timed_out = 0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // predictor: one element item in, maybe one label out
    task automatic predict_element(input lca_in_t it);
        int unsigned dims, pos, best;
        logic [DIST_W-1:0] best_d, dsum;
        longint diff, num, n;
        bit opened;
        lca_out_t res;
        dims = (fcount_q == 0) ? 1 : ((fcount_q > NFEAT) ? NFEAT : fcount_q);
        pos = (elem_pos >= NFEAT) ? NFEAT - 1 : elem_pos;
        best = 0;
        best_d = '0;
        opened = 0;
        row_val[pos] = it.feature_value;
        row_vld[pos] = it.feature_valid;
        if (pos + 1 < dims) begin
            elem_pos = pos + 1;
            return;
        end
        elem_pos = 0;
        // nearest centroid, lowest index on ties
        for (int c = 0; c < n_open; c++) begin
            dsum = '0;
            for (int d = 0; d < dims; d++) begin
                if (row_vld[d]) begin
                    diff = longint'(row_val[d]) - longint'(centroid[c][d]);
                    dsum += DIST_W'(diff * diff);
                end
            end
            if (c == 0 || dsum < best_d) begin
                best_d = dsum;
                best = c;
            end
        end
        // open or overwrite a cluster
        if (n_open == 0 || best_d > thr_q) begin
            if (n_open < NCLU) begin
                best = n_open;
                n_open++;
            end else begin
                best = NCLU - 1;
            end
            for (int d = 0; d < dims; d++) centroid[best][d] = row_val[d];
            opened = 1;
        end
        if (members[best] != COUNT_SAT) members[best]++;
        n = members[best];
        // truncating running mean
        for (int d = 0; d < dims; d++) begin
            if (row_vld[d]) begin
                num = longint'(centroid[best][d]) * (n - 1) + longint'(row_val[d]);
                centroid[best][d] = VALUE_W'(num / n);
            end
        end
        res.cluster_label = best[2:0];
        res.opened_cluster = opened;
        res.clusters_in_use = n_open[3:0];
        expected_labels.push_back(res);
    endtask

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_element(s_item);
                void'(pending_items.pop_front());
            end
            if (!(s_valid && !s_ready)) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_item <= pending_items[0];
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        lca_out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_labels.size() == 0) begin
                    report("unexpected label", m_item.cluster_label, -1);
                end else begin
                    want = expected_labels.pop_front();
                    if (m_item.cluster_label !== want.cluster_label)
                        report("cluster_label", m_item.cluster_label, want.cluster_label);
                    if (m_item.opened_cluster !== want.opened_cluster)
                        report("opened_cluster", m_item.opened_cluster, want.opened_cluster);
                    if (m_item.clusters_in_use !== want.clusters_in_use)
                        report("clusters_in_use", m_item.clusters_in_use,
                               want.clusters_in_use);
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on accepted items of any channel
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
                || (pending_items.size() == 0 && expected_labels.size() == 0))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    function automatic lca_in_t rand_element();
        lca_in_t it;
        it.feature_value = VALUE_W'($urandom);
        it.feature_valid = ($urandom_range(7) != 0);
        return it;
    endfunction

    // rows near a few prototypes so clusters are reused and joined
    task automatic queue_rows(input int n_items, input int spread);
        logic signed [VALUE_W-1:0] proto [4][NFEAT];
        int p;
        lca_in_t it;
        for (int i = 0; i < 4; i++)
            for (int d = 0; d < NFEAT; d++) proto[i][d] = VALUE_W'($urandom);
        p = $urandom_range(3);
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(9) == 0) begin
                it = rand_element();
            end else begin
                it.feature_value = proto[p][i % NFEAT]
                                   + VALUE_W'($urandom_range(2 * spread) - spread);
                it.feature_valid = ($urandom_range(9) != 0);
            end
            if ($urandom_range(5) == 0) p = $urandom_range(3);
            pending_items.push_back(it);
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_valid || expected_labels.size() != 0)
            @(posedge aclk);
        repeat (ROW_LATENCY) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == REG_THRESHOLD) thr_q = val[DIST_W-1:0];
        else if (idx == REG_FEATURE_COUNT) fcount_q = val[FC_W-1:0];
    endtask

    // run one phase of elements under a setting
    task automatic run_phase(input logic [DIST_W-1:0] thr, input logic [FC_W-1:0] fc,
                             input int n_items, input int spread,
                             input int idle_pct, input int stall_pct);
        wait_drained();
        write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
        write_reg(REG_FEATURE_COUNT, CFG_DATA_W'(fc));
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        queue_rows(n_items, spread);
    endtask

    initial begin
        lca_in_t it;
        thr_q = THRESHOLD_RESET;
        fcount_q = FEATURE_COUNT_RESET;
        n_open = 0;
        elem_pos = 0;
        for (int c = 0; c < NCLU; c++) begin
            members[c] = '0;
            for (int d = 0; d < NFEAT; d++) centroid[c][d] = '0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset defaults, extremes of the element fields
        for (int i = 0; i < 16; i++) begin
            it.feature_value = (i % 3 == 0) ? 16'sh7fff : ((i % 3 == 1) ? 16'sh8000 : 16'sh0);
            it.feature_valid = (i != 5);
            pending_items.push_back(it);
        end
        wait_drained();
        // single-element rows: fill all clusters then overwrite the last
        write_reg(REG_FEATURE_COUNT, CFG_DATA_W'(1));
        write_reg(REG_THRESHOLD, CFG_DATA_W'(0));
        for (int i = 0; i < 10; i++) begin
            it.feature_value = VALUE_W'(i * 1000 - 4000);
            it.feature_valid = 1'b1;
            pending_items.push_back(it);
        end
        // a masked element ties at distance zero, lowest index wins
        it.feature_valid = 1'b0;
        pending_items.push_back(it);
        wait_drained();
        // count of zero acts as one, above range acts as the maximum
        write_reg(REG_FEATURE_COUNT, CFG_DATA_W'(0));
        it.feature_value = 16'sh0100;
        it.feature_valid = 1'b1;
        pending_items.push_back(it);
        wait_drained();
        write_reg(REG_FEATURE_COUNT, CFG_DATA_W'(31));
        for (int i = 0; i < 16; i++) pending_items.push_back(rand_element());
        wait_drained();
        // count lowered mid-row completes the row on the next element
        write_reg(REG_FEATURE_COUNT, CFG_DATA_W'(8));
        for (int i = 0; i < 5; i++) pending_items.push_back(rand_element());
        wait_drained();
        write_reg(REG_FEATURE_COUNT, CFG_DATA_W'(3));
        pending_items.push_back(rand_element());

        // random phases
        run_phase(40'd65536, 5'd4, 80, 64, 0, 0);
        run_phase(40'hff_ffff_ffff, 5'd2, 60, 2000, 63, 0);
        run_phase(40'd0, 5'd3, 60, 4, 0, 63);
        run_phase(40'd2000000, 5'd16, 64, 200, 15, 15);
        run_phase(40'd300000, 5'd5, 80, 300, $urandom_range(30), $urandom_range(30));
        // hold the sender until every label is in, then continue
        wait_drained();
        run_phase(40'd1, 5'd1, 60, 2, 15, 15);
        wait_drained();

        if (error_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule
